// ===== rtl/fri_pkg.sv =====
// Shared types and constants of the Fresnel refraction interface unit.
// No dependencies; fri_front, fri_back and the top level refer to this package by scoped names.
package fri_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 20;             // index, Q4.16
    localparam int COS_W     = 18;             // signed cosine, Q1.16
    localparam int FR_W      = 17;             // unsigned fraction, Q1.16
    localparam int Q_W       = 32;             // Q16.16 results
    localparam int SQ_W      = 2 * IDX_W;      // squared index
    localparam int PR_W      = IDX_W + FR_W;   // index times cosine
    localparam int WP_W      = SQ_W + FR_W;    // squared index times cosine
    localparam int U_W       = 2 * FRAC_BITS + 1;
    localparam int DIFF_W    = SQ_W + 2 * FRAC_BITS;

    localparam logic [FR_W-1:0]        ONE_Q  = FR_W'(1) << FRAC_BITS;
    localparam logic [2*FRAC_BITS:0]   ONE_SQ = (2*FRAC_BITS+1)'(1) << (2*FRAC_BITS);
    localparam logic [Q_W-1:0]         SAT32  = '1;

    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TIR     = 2'd2;

    // classified request, front to back
    typedef struct packed {
        logic [1:0]        status;
        logic [COS_W-1:0]  cos_out;
        logic [FR_W-1:0]   ci;
        logic [IDX_W-1:0]  ei;
        logic [IDX_W-1:0]  et;
        logic [SQ_W-1:0]   ei2;
        logic [SQ_W-1:0]   et2;
        logic [DIFF_W-1:0] num;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [COS_W-1:0] cos_out;
        logic [FR_W-1:0]  ci;
        logic [IDX_W-1:0] ei;
        logic [IDX_W-1:0] et;
        logic [SQ_W-1:0]  ei2;
        logic [SQ_W-1:0]  et2;
    } t_tag_a;

    typedef struct packed {
        logic [1:0]       status;
        logic [COS_W-1:0] cos_out;
        logic [FR_W-1:0]  ct;
        logic [SQ_W-1:0]  ei2;
        logic [SQ_W-1:0]  et2;
    } t_tag_b;

    typedef struct packed {
        logic [WP_W-1:0] et2ct;
        logic [WP_W-1:0] ei2ci;
    } t_tag_c;

    typedef struct packed {
        logic [1:0]       status;
        logic [COS_W-1:0] cos_out;
        logic [FR_W-1:0]  ct;
        logic [SQ_W-1:0]  ei2;
        logic [SQ_W-1:0]  et2;
        logic [WP_W-1:0]  et2ct;
        logic [WP_W-1:0]  ei2ci;
        logic [FR_W-1:0]  refl;
        logic [FR_W-1:0]  trans;
    } t_mid;

    typedef struct packed {
        logic [1:0]       status;
        logic [COS_W-1:0] cos_out;
        logic [FR_W-1:0]  ct;
        logic [FR_W-1:0]  refl;
        logic [FR_W-1:0]  trans;
        logic             sat;
    } t_tag_d;

    typedef struct packed {
        logic [1:0]       status;
        logic [COS_W-1:0] cos_out;
        logic [FR_W-1:0]  cos_t;
        logic [FR_W-1:0]  refl;
        logic [FR_W-1:0]  trans;
        logic [Q_W-1:0]   jac_fwd;
        logic [Q_W-1:0]   jac_rev;
        logic [Q_W-1:0]   density;
        logic [Q_W-1:0]   scale;
    } t_result;

endpackage

// ===== rtl/fresnel_refraction_interface_unit.sv =====
// Top level of the Fresnel refraction interface unit: front end, request queue,
// back end and result queue. Depends on fri_pkg, fri_front, fri_fifo and fri_back.
//
//   channel   | direction | handshake            | payload
//   ----------+-----------+----------------------+---------------------------------------
//   request   | in        | push / full          | indices Q4.16, incident cosine Q1.16
//   result    | out       | empty / pop          | status, cosines, R, T, Jacobians, pdf,
//             |           |                      | radiance gain
//
// One request enters per cycle while full is low, and one result leaves per cycle
// while the receiver pops, sustained. Latency is set by the chain of bit-per-stage
// dividers (33 + 17 + 32 quotient bits) and the square root (17 root bits).
// Reset (synchronous, active low) clears the valid bits and queue pointers only.
// A full result queue freezes the back end; the request queue then fills and full
// rises, so the front end holds its two stages until the back end moves again.
module fresnel_refraction_interface_unit #(
    parameter int Q_DEPTH   = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [fri_pkg::IDX_W-1:0]         i_index_incident,
    input  logic [fri_pkg::IDX_W-1:0]         i_index_transmitted,
    input  logic signed [fri_pkg::COS_W-1:0]  i_cos_incident_in,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_status,
    output logic signed [fri_pkg::COS_W-1:0]  o_cos_incident_out,
    output logic [fri_pkg::FR_W-1:0]          o_cos_transmitted,
    output logic [fri_pkg::FR_W-1:0]          o_reflectance,
    output logic [fri_pkg::FR_W-1:0]          o_transmittance,
    output logic [fri_pkg::Q_W-1:0]           o_jacobian_forward,
    output logic [fri_pkg::Q_W-1:0]           o_jacobian_reverse,
    output logic [fri_pkg::Q_W-1:0]           o_manifold_density,
    output logic [fri_pkg::Q_W-1:0]           o_radiance_gain
);
    // front end to request queue
    logic            q_push, q_full, q_empty, q_pop;
    fri_pkg::t_item  q_in, q_out;

    // back end to result queue
    logic              b_en, b_vld, r_full;
    fri_pkg::t_result  b_res, r_out;

    fri_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push),
        .i_ei(i_index_incident), .i_et(i_index_transmitted), .i_cos(i_cos_incident_in),
        .o_full(full), .i_q_full(q_full), .o_q_push(q_push), .o_q_item(q_in)
    );

    fri_fifo #(.W($bits(fri_pkg::t_item)), .DEPTH(Q_DEPTH)) u_req_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(q_push), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_empty(q_empty), .o_data(q_out)
    );

    // advance the back end whenever the result queue has room; drain a request each step if one is queued
    assign b_en  = !r_full;
    assign q_pop = b_en && !q_empty;

    fri_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(b_en),
        .i_vld(q_pop), .i_item(q_out),
        .o_vld(b_vld), .o_res(b_res)
    );

    fri_fifo #(.W($bits(fri_pkg::t_result)), .DEPTH(OUT_DEPTH)) u_res_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(b_vld && b_en), .i_data(b_res), .o_full(r_full),
        .i_pop(pop), .o_empty(empty), .o_data(r_out)
    );

    // oldest result on the ports
    assign o_status           = r_out.status;
    assign o_cos_incident_out = signed'(r_out.cos_out);
    assign o_cos_transmitted  = r_out.cos_t;
    assign o_reflectance      = r_out.refl;
    assign o_transmittance    = r_out.trans;
    assign o_jacobian_forward = r_out.jac_fwd;
    assign o_jacobian_reverse = r_out.jac_rev;
    assign o_manifold_density = r_out.density;
    assign o_radiance_gain    = r_out.scale;

endmodule

// ===== rtl/fri_fifo.sv =====
// Small register queue with a combinational head, used on both sides of the back end.
// Depends on nothing; DEPTH must be a power of two of at least two.
module fri_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + AW'(1);
            if (do_pop)  r_rd <= r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

// ===== rtl/fri_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a tag carried alongside.
// Depends on nothing; the caller keeps the numerator's upper part below the divisor.
module fri_div #(
    parameter int NW = 72,
    parameter int DW = 40,
    parameter int QW = 33,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [QW:0]   r_vld;
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_acc [QW+1];
    logic [DW-1:0] r_den [QW+1];
    logic [TW-1:0] r_tag [QW+1];

    // load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num >> QW);
            r_acc[0] <= i_num[QW-1:0];
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] n_trial;
        logic [DW:0] n_diff;
        logic        n_ge;

        assign n_trial = {r_rem[k-1], r_acc[k-1][QW-1]};
        assign n_diff  = n_trial - {1'b0, r_den[k-1]};
        assign n_ge    = !n_diff[DW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_vld[k] <= 1'b0;
            else if (i_en) r_vld[k] <= r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
                r_acc[k] <= {r_acc[k-1][QW-2:0], n_ge};
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_vld = r_vld[QW];
    assign o_quo = r_acc[QW];
    assign o_tag = r_tag[QW];

endmodule

// ===== rtl/fri_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage, with a tag.
// Depends on nothing; IW must be even.
module fri_sqrt #(
    parameter int IW = 34,
    parameter int TW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [IW-1:0]   i_rad,
    input  logic [TW-1:0]   i_tag,
    output logic            o_vld,
    output logic [IW/2-1:0] o_root,
    output logic [TW-1:0]   o_tag
);
    localparam int RW = IW / 2;

    logic [RW:0]   r_vld;
    logic [RW+1:0] r_rem  [RW+1];
    logic [RW-1:0] r_root [RW+1];
    logic [IW-1:0] r_rad  [RW+1];
    logic [TW-1:0] r_tag  [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vld[0] <= 1'b0;
        else if (i_en) r_vld[0] <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_rad[0]  <= i_rad;
            r_tag[0]  <= i_tag;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_step
        logic [RW+3:0] n_cur;
        logic [RW+3:0] n_diff;
        logic          n_ge;

        assign n_cur  = {r_rem[k-1], r_rad[k-1][IW-1:IW-2]};
        assign n_diff = n_cur - {2'b00, r_root[k-1], 2'b01};
        assign n_ge   = !n_diff[RW+3];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)  r_vld[k] <= 1'b0;
            else if (i_en) r_vld[k] <= r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_ge ? n_diff[RW+1:0] : n_cur[RW+1:0];
                r_root[k] <= {r_root[k-1][RW-2:0], n_ge};
                r_rad[k]  <= {r_rad[k-1][IW-3:0], 2'b00};
                r_tag[k]  <= r_tag[k-1];
            end
        end
    end

    assign o_vld  = r_vld[RW];
    assign o_root = r_root[RW];
    assign o_tag  = r_tag[RW];

endmodule

// ===== rtl/fri_front.sv =====
// Front end: clamp and square the operands, classify the request, feed the queue.
// Depends on fri_pkg.
module fri_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic [fri_pkg::IDX_W-1:0]         i_ei,
    input  logic [fri_pkg::IDX_W-1:0]         i_et,
    input  logic signed [fri_pkg::COS_W-1:0]  i_cos,
    output logic                              o_full,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output fri_pkg::t_item                    o_q_item
);
    localparam logic signed [fri_pkg::COS_W-1:0] COS_HI =
        fri_pkg::COS_W'(signed'({1'b0, fri_pkg::ONE_Q}));
    localparam logic signed [fri_pkg::COS_W-1:0] COS_LO = -COS_HI;

    logic f_adv, accept;

    logic signed [fri_pkg::COS_W-1:0] n_cs;
    logic [fri_pkg::FR_W-1:0]         n_ci;
    logic                             n_bad;

    logic                          r_f1_vld, r_f2_vld;
    logic [fri_pkg::IDX_W-1:0]     r_f1_ei, r_f1_et, r_f2_ei, r_f2_et;
    logic [fri_pkg::COS_W-1:0]     r_f1_cos, r_f2_cos;
    logic [fri_pkg::FR_W-1:0]      r_f1_ci, r_f2_ci;
    logic                          r_f1_bad, r_f2_bad;
    logic [fri_pkg::SQ_W-1:0]      r_f1_ei2, r_f1_et2, r_f2_ei2, r_f2_et2;
    logic [2*fri_pkg::FRAC_BITS:0] r_f1_ci2;
    logic [fri_pkg::DIFF_W-1:0]    r_f2_b;

    logic [2*fri_pkg::FRAC_BITS:0] n_s;
    logic [fri_pkg::DIFF_W:0]      n_d;
    logic                          n_tir;

    assign f_adv  = !(r_f2_vld && i_q_full);
    assign o_full = !f_adv;
    assign accept = i_push && f_adv;

    // clamp the cosine, take its magnitude
    always_comb begin
        if (i_cos > COS_HI)      n_cs = COS_HI;
        else if (i_cos < COS_LO) n_cs = COS_LO;
        else                     n_cs = i_cos;
        n_ci  = n_cs[fri_pkg::COS_W-1] ? fri_pkg::FR_W'(-n_cs) : n_cs[fri_pkg::FR_W-1:0];
        n_bad = (i_ei == '0) || (i_et == '0) || (n_cs == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
        end else if (f_adv) begin
            r_f1_vld <= accept;
            r_f2_vld <= r_f1_vld;
        end
    end

    assign n_s = fri_pkg::ONE_SQ - r_f1_ci2;

    always_ff @(posedge i_clk) begin
        if (f_adv) begin
            r_f1_ei  <= i_ei;
            r_f1_et  <= i_et;
            r_f1_cos <= n_bad ? n_cs : {1'b0, n_ci};
            r_f1_ci  <= n_ci;
            r_f1_bad <= n_bad;
            r_f1_ei2 <= fri_pkg::SQ_W'(i_ei) * fri_pkg::SQ_W'(i_ei);
            r_f1_et2 <= fri_pkg::SQ_W'(i_et) * fri_pkg::SQ_W'(i_et);
            r_f1_ci2 <= (2*fri_pkg::FRAC_BITS+1)'(n_ci) * (2*fri_pkg::FRAC_BITS+1)'(n_ci);

            r_f2_ei  <= r_f1_ei;
            r_f2_et  <= r_f1_et;
            r_f2_cos <= r_f1_cos;
            r_f2_ci  <= r_f1_ci;
            r_f2_bad <= r_f1_bad;
            r_f2_ei2 <= r_f1_ei2;
            r_f2_et2 <= r_f1_et2;
            // the sine term never needs its top bit for a valid cosine
            r_f2_b   <= fri_pkg::DIFF_W'(r_f1_ei2) *
                        fri_pkg::DIFF_W'(n_s[2*fri_pkg::FRAC_BITS-1:0]);
        end
    end

    // total internal reflection when the sine term reaches the transmitted one
    assign n_d   = {1'b0, r_f2_et2, {(2*fri_pkg::FRAC_BITS){1'b0}}} - {1'b0, r_f2_b};
    assign n_tir = n_d[fri_pkg::DIFF_W] || (n_d[fri_pkg::DIFF_W-1:0] == '0);

    assign o_q_push = r_f2_vld && !i_q_full;

    always_comb begin
        o_q_item.status  = r_f2_bad ? fri_pkg::ST_INVALID :
                           n_tir    ? fri_pkg::ST_TIR     : fri_pkg::ST_READY;
        o_q_item.cos_out = r_f2_cos;
        o_q_item.ci      = r_f2_ci;
        o_q_item.ei      = r_f2_ei;
        o_q_item.et      = r_f2_et;
        o_q_item.ei2     = r_f2_ei2;
        o_q_item.et2     = r_f2_et2;
        o_q_item.num     = n_d[fri_pkg::DIFF_W-1:0];
    end

endmodule

// ===== rtl/fri_back.sv =====
// Back end: transmitted cosine, reflectance, Jacobians, density and scale, one per cycle while i_en holds.
// Depends on fri_pkg, fri_div and fri_sqrt.
module fri_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  fri_pkg::t_item    i_item,
    output logic              o_vld,
    output fri_pkg::t_result  o_res
);
    localparam int F    = fri_pkg::FRAC_BITS;
    localparam int FR_W = fri_pkg::FR_W;
    localparam int PR_W = fri_pkg::PR_W;
    localparam int WP_W = fri_pkg::WP_W;
    localparam int SQ_W = fri_pkg::SQ_W;
    localparam int Q_W  = fri_pkg::Q_W;

    // ---- transmitted cosine: divide, then root
    fri_pkg::t_tag_a          tag_a_in, tag_a_u, tag_a_s;
    logic                     u_vld, s_vld;
    logic [fri_pkg::U_W-1:0]  u_quo;
    logic [FR_W-1:0]          s_ct;

    always_comb begin
        tag_a_in.status  = i_item.status;
        tag_a_in.cos_out = i_item.cos_out;
        tag_a_in.ci      = i_item.ci;
        tag_a_in.ei      = i_item.ei;
        tag_a_in.et      = i_item.et;
        tag_a_in.ei2     = i_item.ei2;
        tag_a_in.et2     = i_item.et2;
    end

    fri_div #(
        .NW(fri_pkg::DIFF_W), .DW(SQ_W), .QW(fri_pkg::U_W), .TW($bits(fri_pkg::t_tag_a))
    ) u_div_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(i_vld),
        .i_num(i_item.num), .i_den(i_item.et2), .i_tag(tag_a_in),
        .o_vld(u_vld), .o_quo(u_quo), .o_tag(tag_a_u)
    );

    fri_sqrt #(.IW(2*FR_W), .TW($bits(fri_pkg::t_tag_a))) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(u_vld),
        .i_rad({1'b0, u_quo}), .i_tag(tag_a_u),
        .o_vld(s_vld), .o_root(s_ct), .o_tag(tag_a_s)
    );

    // ---- cross products
    logic                r_m1_vld;
    fri_pkg::t_tag_b     r_m1_b;
    fri_pkg::t_tag_c     r_m1_c;
    logic [PR_W-1:0]     r_ei_ci, r_et_ct, r_et_ci, r_ei_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_m1_vld <= 1'b0;
        else if (i_en) r_m1_vld <= s_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_b.status  <= tag_a_s.status;
            r_m1_b.cos_out <= tag_a_s.cos_out;
            r_m1_b.ct      <= s_ct;
            r_m1_b.ei2     <= tag_a_s.ei2;
            r_m1_b.et2     <= tag_a_s.et2;
            r_m1_c.et2ct   <= WP_W'(tag_a_s.et2) * WP_W'(s_ct);
            r_m1_c.ei2ci   <= WP_W'(tag_a_s.ei2) * WP_W'(tag_a_s.ci);
            r_ei_ci        <= PR_W'(tag_a_s.ei) * PR_W'(tag_a_s.ci);
            r_et_ct        <= PR_W'(tag_a_s.et) * PR_W'(s_ct);
            r_et_ci        <= PR_W'(tag_a_s.et) * PR_W'(tag_a_s.ci);
            r_ei_ct        <= PR_W'(tag_a_s.ei) * PR_W'(s_ct);
        end
    end

    // ---- s and p amplitude ratios
    logic [PR_W-1:0] n_dif_s, n_dif_p;
    logic [PR_W:0]   n_sum_s, n_sum_p;

    assign n_dif_s = (r_ei_ci >= r_et_ct) ? r_ei_ci - r_et_ct : r_et_ct - r_ei_ci;
    assign n_dif_p = (r_et_ci >= r_ei_ct) ? r_et_ci - r_ei_ct : r_ei_ct - r_et_ci;
    assign n_sum_s = {1'b0, r_ei_ci} + {1'b0, r_et_ct};
    assign n_sum_p = {1'b0, r_et_ci} + {1'b0, r_ei_ct};

    logic             rs_vld;
    logic [FR_W-1:0]  rs_quo, rp_quo;
    fri_pkg::t_tag_b  tag_b;
    fri_pkg::t_tag_c  tag_c;

    fri_div #(.NW(PR_W+F), .DW(PR_W+1), .QW(FR_W), .TW($bits(fri_pkg::t_tag_b))) u_div_rs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(r_m1_vld),
        .i_num({n_dif_s, {F{1'b0}}}), .i_den(n_sum_s), .i_tag(r_m1_b),
        .o_vld(rs_vld), .o_quo(rs_quo), .o_tag(tag_b)
    );

    fri_div #(.NW(PR_W+F), .DW(PR_W+1), .QW(FR_W), .TW($bits(fri_pkg::t_tag_c))) u_div_rp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(r_m1_vld),
        .i_num({n_dif_p, {F{1'b0}}}), .i_den(n_sum_p), .i_tag(r_m1_c),
        .o_vld(), .o_quo(rp_quo), .o_tag(tag_c)
    );

    // ---- reflectance, transmittance, scale numerator
    logic               r_q1_vld, r_q2_vld, r_q3_vld;
    fri_pkg::t_mid      r_q1, r_q2, r_q3;
    fri_pkg::t_mid      n_q2;
    logic [2*FR_W-1:0]  r_rs2, r_rp2;
    logic [WP_W-1:0]    r_tei2;
    logic [FR_W:0]      n_rsum;
    logic [FR_W-1:0]    n_refl;

    // a squared ratio never exceeds one, so its top bit stays clear
    assign n_rsum = {1'b0, r_rs2[2*FR_W-2:F]} + {1'b0, r_rp2[2*FR_W-2:F]};
    assign n_refl = (n_rsum[FR_W:1] > fri_pkg::ONE_Q) ? fri_pkg::ONE_Q : n_rsum[FR_W:1];

    always_comb begin
        n_q2       = r_q1;
        n_q2.refl  = n_refl;
        n_q2.trans = fri_pkg::ONE_Q - n_refl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1_vld <= 1'b0;
            r_q2_vld <= 1'b0;
            r_q3_vld <= 1'b0;
        end else if (i_en) begin
            r_q1_vld <= rs_vld;
            r_q2_vld <= r_q1_vld;
            r_q3_vld <= r_q2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1.status  <= tag_b.status;
            r_q1.cos_out <= tag_b.cos_out;
            r_q1.ct      <= tag_b.ct;
            r_q1.ei2     <= tag_b.ei2;
            r_q1.et2     <= tag_b.et2;
            r_q1.et2ct   <= tag_c.et2ct;
            r_q1.ei2ci   <= tag_c.ei2ci;
            r_q1.refl    <= '0;
            r_q1.trans   <= '0;
            r_rs2        <= (2*FR_W)'(rs_quo) * (2*FR_W)'(rs_quo);
            r_rp2        <= (2*FR_W)'(rp_quo) * (2*FR_W)'(rp_quo);

            r_q2         <= n_q2;

            r_q3         <= r_q2;
            r_tei2       <= WP_W'(r_q2.trans) * WP_W'(r_q2.ei2);
        end
    end

    // ---- Jacobians and scale, with overflow decided up front
    logic [WP_W-1:0] n_den_f;
    logic            n_sat_f, n_sat_r, n_sat_t;

    assign n_den_f = (r_q3.et2ct == '0) ? WP_W'(1) : r_q3.et2ct;
    assign n_sat_f = {{F{1'b0}}, r_q3.ei2ci} >= {n_den_f, {F{1'b0}}};
    assign n_sat_r = {{F{1'b0}}, r_q3.et2ct} >= {r_q3.ei2ci, {F{1'b0}}};
    assign n_sat_t = {{(SQ_W+Q_W-WP_W){1'b0}}, r_tei2} >= {r_q3.et2, {Q_W{1'b0}}};

    fri_pkg::t_tag_d tag_d_in, tag_d;
    logic            jf_vld, sat_r, sat_t;
    logic [Q_W-1:0]  jf_quo, jr_quo, ts_quo;

    always_comb begin
        tag_d_in.status  = r_q3.status;
        tag_d_in.cos_out = r_q3.cos_out;
        tag_d_in.ct      = r_q3.ct;
        tag_d_in.refl    = r_q3.refl;
        tag_d_in.trans   = r_q3.trans;
        tag_d_in.sat     = n_sat_f;
    end

    fri_div #(.NW(WP_W+F), .DW(WP_W), .QW(Q_W), .TW($bits(fri_pkg::t_tag_d))) u_div_jf (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(r_q3_vld),
        .i_num(n_sat_f ? '0 : {r_q3.ei2ci, {F{1'b0}}}), .i_den(n_den_f), .i_tag(tag_d_in),
        .o_vld(jf_vld), .o_quo(jf_quo), .o_tag(tag_d)
    );

    fri_div #(.NW(WP_W+F), .DW(WP_W), .QW(Q_W), .TW(1)) u_div_jr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(r_q3_vld),
        .i_num(n_sat_r ? '0 : {r_q3.et2ct, {F{1'b0}}}), .i_den(r_q3.ei2ci),
        .i_tag(n_sat_r),
        .o_vld(), .o_quo(jr_quo), .o_tag(sat_r)
    );

    fri_div #(.NW(WP_W), .DW(SQ_W), .QW(Q_W), .TW(1)) u_div_ts (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en), .i_vld(r_q3_vld),
        .i_num(n_sat_t ? '0 : r_tei2), .i_den(r_q3.et2), .i_tag(n_sat_t),
        .o_vld(), .o_quo(ts_quo), .o_tag(sat_t)
    );

    // ---- density product and final selection
    logic                 r_p1_vld;
    fri_pkg::t_tag_d      r_p1;
    logic [Q_W-1:0]       r_jf, r_jr, r_ts;
    logic [Q_W+FR_W-1:0]  r_pdfp;
    logic [Q_W-1:0]       n_jf;
    logic [Q_W:0]         n_pdf;

    assign n_jf = tag_d.sat ? fri_pkg::SAT32 : jf_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_p1_vld <= 1'b0;
        else if (i_en) r_p1_vld <= jf_vld;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= tag_d;
            r_jf   <= n_jf;
            r_jr   <= sat_r ? fri_pkg::SAT32 : jr_quo;
            r_ts   <= sat_t ? fri_pkg::SAT32 : ts_quo;
            r_pdfp <= (Q_W+FR_W)'(tag_d.trans) * (Q_W+FR_W)'(n_jf);
        end
    end

    assign n_pdf = r_pdfp[Q_W+FR_W-1:F];
    assign o_vld = r_p1_vld;

    always_comb begin
        o_res         = '0;
        o_res.status  = r_p1.status;
        o_res.cos_out = r_p1.cos_out;
        unique case (r_p1.status)
            fri_pkg::ST_READY: begin
                o_res.cos_t   = r_p1.ct;
                o_res.refl    = r_p1.refl;
                o_res.trans   = r_p1.trans;
                o_res.jac_fwd = r_jf;
                o_res.jac_rev = r_jr;
                o_res.density = n_pdf[Q_W] ? fri_pkg::SAT32 : n_pdf[Q_W-1:0];
                o_res.scale   = r_ts;
            end
            fri_pkg::ST_TIR: begin
                o_res.refl = fri_pkg::ONE_Q;
            end
            fri_pkg::ST_INVALID: begin
                o_res.cos_out = r_p1.cos_out;
            end
            default: begin
                o_res.cos_out = '0;
            end
        endcase
    end

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for fresnel_refraction_interface_unit: random and directed requests.
// Depends on fri_pkg and the rtl top level; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic [1:0]                 status;
        logic [fri_pkg::COS_W-1:0]  cos_in;
        logic [fri_pkg::FR_W-1:0]   cos_t;
        logic [fri_pkg::FR_W-1:0]   refl;
        logic [fri_pkg::FR_W-1:0]   trans;
        logic [fri_pkg::Q_W-1:0]    jac_fwd;
        logic [fri_pkg::Q_W-1:0]    jac_rev;
        logic [fri_pkg::Q_W-1:0]    density;
        logic [fri_pkg::Q_W-1:0]    scale;
    } t_fresnel;

    class t_board;
        t_fresnel pending[$];
        int errors;

        function automatic logic [31:0] sat(logic [255:0] v);
            return (v > 256'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        endfunction

        function automatic logic [63:0] isqrt(logic [63:0] x);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Work out the result of one request and queue it.
        function void note_request(logic [19:0] ei, logic [19:0] et, logic [17:0] raw);
            t_fresnel e;
            longint c;
            logic [255:0] ci, ei2, et2, one, a, b, u, ct, p, q, r, t, rs, rp, rr, tt, jf, den;
            one = 256'd1 << fri_pkg::FRAC_BITS;
            c = longint'($signed(raw));
            if (c > 65536) c = 65536;
            if (c < -65536) c = -65536;
            e = '{default: '0};
            if (ei == 0 || et == 0 || c == 0) begin
                e.status = fri_pkg::ST_INVALID;
                e.cos_in = fri_pkg::COS_W'(c);
                pending.push_back(e);
                return;
            end
            ci = (c < 0) ? -c : c;
            e.cos_in = fri_pkg::COS_W'(ci);
            ei2 = ei * ei;
            et2 = et * et;
            a = et2 * one * one;
            b = ei2 * (one * one - ci * ci);
            if (b >= a) begin
                e.status = fri_pkg::ST_TIR;
                e.refl = fri_pkg::ONE_Q;
                pending.push_back(e);
                return;
            end
            u = (a - b) / et2;
            ct = 256'(isqrt(u[63:0]));
            p = ei * ci; q = et * ct; r = et * ci; t = ei * ct;
            if (p + q == 0 || r + t == 0) begin
                rr = one;
            end else begin
                rs = ((p >= q ? p - q : q - p) * one) / (p + q);
                rp = ((r >= t ? r - t : t - r) * one) / (r + t);
                rr = (((rs * rs) >> fri_pkg::FRAC_BITS) + ((rp * rp) >> fri_pkg::FRAC_BITS)) >> 1;
                if (rr > one) rr = one;
            end
            tt = one - rr;
            den = et2 * ct;
            if (den == 0) den = 1;
            jf = 256'(sat(((ei2 * ci) << fri_pkg::FRAC_BITS) / den));
            e.status = fri_pkg::ST_READY;
            e.cos_t = fri_pkg::FR_W'(ct);
            e.refl = fri_pkg::FR_W'(rr);
            e.trans = fri_pkg::FR_W'(tt);
            e.jac_fwd = jf[31:0];
            e.jac_rev = sat(((et2 * ct) << fri_pkg::FRAC_BITS) / (ei2 * ci));
            e.density = sat((tt * jf) >> fri_pkg::FRAC_BITS);
            e.scale = sat((tt * ei2) / et2);
            pending.push_back(e);
        endfunction

        function void cmp(string n, logic [63:0] exp_v, logic [63:0] got);
            if (exp_v !== got) begin
                $display("%0t mismatch %s: expected %0h actual %0h", $realtime, n, exp_v, got);
                errors++;
            end
        endfunction

        // Compare one popped result with the oldest prediction.
        function void check_result(t_fresnel g);
            t_fresnel e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result, status %0d", $realtime, g.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("status", 64'(e.status), 64'(g.status));
            cmp("cos_incident_out", 64'(e.cos_in), 64'(g.cos_in));
            cmp("cos_transmitted", 64'(e.cos_t), 64'(g.cos_t));
            cmp("reflectance", 64'(e.refl), 64'(g.refl));
            cmp("transmittance", 64'(e.trans), 64'(g.trans));
            cmp("jacobian_forward", 64'(e.jac_fwd), 64'(g.jac_fwd));
            cmp("jacobian_reverse", 64'(e.jac_rev), 64'(g.jac_rev));
            cmp("manifold_density", 64'(e.density), 64'(g.density));
            cmp("radiance_gain", 64'(e.scale), 64'(g.scale));
        endfunction
    endclass

    logic i_clk, i_rst_n, push, pop, full, empty;
    logic [fri_pkg::IDX_W-1:0] i_index_incident, i_index_transmitted;
    logic signed [fri_pkg::COS_W-1:0] i_cos_incident_in;
    logic [1:0] o_status;
    logic signed [fri_pkg::COS_W-1:0] o_cos_incident_out;
    logic [fri_pkg::FR_W-1:0] o_cos_transmitted, o_reflectance, o_transmittance;
    logic [fri_pkg::Q_W-1:0] o_jacobian_forward, o_jacobian_reverse, o_manifold_density;
    logic [fri_pkg::Q_W-1:0] o_radiance_gain;

    t_board board;
    bit quiet_tail;     // drop all idling near the end
    bit hold_results;   // long receiver hold-off
    int idle_cycles;

    fresnel_refraction_interface_unit dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Present one request; hold it until accepted.
    task automatic send_request(logic [19:0] ei, logic [19:0] et, logic [17:0] c);
        push <= 1;
        i_index_incident <= ei;
        i_index_transmitted <= et;
        i_cos_incident_in <= c;
        do @(posedge i_clk); while (full);
        board.note_request(ei, et, c);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Mostly physical indices near 1..3, sometimes any value or one near zero or the maximum.
    function automatic logic [19:0] pick_index();
        case ($urandom_range(0, 9))
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 3));
            2: return 20'hFFFFF - 20'($urandom_range(0, 3));
            default: return 20'($urandom_range(65536, 3 * 65536));
        endcase
    endfunction

    function automatic logic [17:0] pick_cos();
        case ($urandom_range(0, 7))
            0: return 18'($urandom);
            1: return 18'($signed($urandom_range(0, 6)) - 3);
            default: return 18'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Receiver: pop with random stalls, or hold off when asked.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_result('{o_status, o_cos_incident_out, o_cos_transmitted,
                o_reflectance, o_transmittance, o_jacobian_forward, o_jacobian_reverse,
                o_manifold_density, o_radiance_gain});
        if (idle_cycles > 0) begin
            idle_cycles <= idle_cycles - 1;
            pop <= 0;
        end else if (hold_results || !i_rst_n) begin
            pop <= 0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            idle_cycles <= $urandom_range(0, 3);
            pop <= 0;
        end else begin
            pop <= 1;
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    int stuck;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) stuck <= 0;
        else stuck <= stuck + 1;
        if (stuck > 20000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [17:0] dir_cos[6];
        board = new();
        push = 0; pop = 0; i_rst_n = 0; quiet_tail = 0; hold_results = 0; idle_cycles = 0;
        i_index_incident = 0; i_index_transmitted = 0; i_cos_incident_in = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: invalid, clamp, normal and grazing incidence, TIR, index extremes.
        dir_cos = '{18'h10000, 18'h30000, 18'h1FFFF, 18'h20000, 18'd1, 18'd0};
        foreach (dir_cos[i]) send_request(20'h10000, 20'h18000, dir_cos[i]);
        send_request(20'h0, 20'h10000, 18'h08000);
        send_request(20'h10000, 20'h0, 18'h08000);
        send_request(20'h18000, 20'h10000, 18'd100);
        send_request(20'h30000, 20'h10000, 18'h04000);
        send_request(20'h10000, 20'h10000, 18'h08000);
        send_request(20'hFFFFF, 20'd1, 18'h10000);
        send_request(20'd1, 20'hFFFFF, 18'h10000);
        send_request(20'hFFFFF, 20'hFFFFF, 18'h3FFFF);
        send_request(20'd1, 20'hFFFFF, 18'd1);
        send_request(20'hFFFFF, 20'd1, 18'd1);

        // Hold the receiver off so both queues fill and full rises.
        hold_results = 1;
        fork
            begin
                int n;
                for (n = 0; n < 150 && !full; n++) @(posedge i_clk);
                repeat (150) @(posedge i_clk);
                hold_results = 0;
            end
            for (int k = 0; k < 200; k++) send_request(pick_index(), pick_index(), pick_cos());
        join
        // Pause until every queued result is back.
        push <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);

        for (int k = 0; k < 1530; k++) begin
            if (k == 1300) quiet_tail = 1;
            send_request(pick_index(), pick_index(), pick_cos());
        end
        push <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
